FILE: sv/mlet_pkg.sv
// Shared constants, codes and controller/datapath interface types for the line envelope tree.
package mlet_pkg;

  localparam int unsigned POINTS  = 1024;
  localparam int unsigned PIDX_W  = $clog2(POINTS);
  localparam int unsigned CNT_W   = PIDX_W + 1;
  localparam int unsigned NODES   = 2 * POINTS;
  localparam int unsigned NIDX_W  = PIDX_W + 1;
  localparam int unsigned EPOCH_W = 8;
  localparam int unsigned NODE_W  = EPOCH_W + 64;

  localparam logic signed [63:0] NO_LINE = 64'sh0FFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_ADD   = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_CLEAR,
    OP_LD_RD,
    OP_LD_SHIFT,
    OP_LD_WR,
    OP_AD_RD,
    OP_AD_PUT,
    OP_AD_XL,
    OP_AD_XM,
    OP_AD_XR,
    OP_AD_MUL,
    OP_AD_ACC,
    OP_AD_STEP,
    OP_QB_RD,
    OP_QB_CMP,
    OP_QF_RD,
    OP_QW_INIT,
    OP_QW_RD,
    OP_QW_MUL,
    OP_QW_ACC,
    OP_FIN,
    OP_SWEEP
  } op_e;

  typedef enum logic [1:0] {
    FIN_OK,
    FIN_FULL,
    FIN_NF,
    FIN_QRY
  } fin_e;

  typedef struct packed {
    op_e  op;
    fin_e fin;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       cnt_full;
    logic       cnt_zero;
    logic       epoch_zero;
    logic       sweep_last;
    logic       p_zero;
    logic       prd_gt_x;
    logic       prd_ne_x;
    logic       lo_lt_hi;
    logic       lo_ge_cnt;
    logic       node_hit;
    logic       dec_keep;
    logic       dec_take;
    logic       w_le1;
    logic       e_last;
    logic       i_one;
    logic       out_free;
  } dp_sts_t;

endpackage

FILE: sv/mlet_ctrl.sv
// Sequencing state machine for load, add-line, query, clear and the tag clearing pass.
module mlet_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mlet_pkg::dp_sts_t  sts_i,
  output mlet_pkg::ctl_cmd_t cmd_o
);
  import mlet_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_DISP   = 5'd1;
  localparam logic [4:0] S_LD_RD  = 5'd2;
  localparam logic [4:0] S_LD_CMP = 5'd3;
  localparam logic [4:0] S_LD_WR  = 5'd4;
  localparam logic [4:0] S_AD_NRD = 5'd5;
  localparam logic [4:0] S_AD_XL  = 5'd6;
  localparam logic [4:0] S_AD_XM  = 5'd7;
  localparam logic [4:0] S_AD_XR  = 5'd8;
  localparam logic [4:0] S_AD_MUL = 5'd9;
  localparam logic [4:0] S_AD_ACC = 5'd10;
  localparam logic [4:0] S_AD_DEC = 5'd11;
  localparam logic [4:0] S_QB_CHK = 5'd12;
  localparam logic [4:0] S_QB_CMP = 5'd13;
  localparam logic [4:0] S_QF_RD  = 5'd14;
  localparam logic [4:0] S_QF_CHK = 5'd15;
  localparam logic [4:0] S_QW_RD  = 5'd16;
  localparam logic [4:0] S_QW_MUL = 5'd17;
  localparam logic [4:0] S_QW_ACC = 5'd18;
  localparam logic [4:0] S_FIN    = 5'd19;
  localparam logic [4:0] S_SWEEP  = 5'd20;

  logic [4:0] state_q, state_d;
  fin_e       fin_q, fin_d;
  op_e        op;

  always_comb begin
    state_d = state_q;
    fin_d   = fin_q;
    op      = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op      = OP_ACCEPT;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        case (sts_i.cmd)
          CMD_LOAD: begin
            if (sts_i.cnt_full) begin
              fin_d   = FIN_FULL;
              state_d = S_FIN;
            end else begin
              state_d = S_LD_RD;
            end
          end
          CMD_ADD: begin
            if (sts_i.cnt_zero) begin
              fin_d   = FIN_OK;
              state_d = S_FIN;
            end else begin
              state_d = S_AD_NRD;
            end
          end
          CMD_QUERY: state_d = S_QB_CHK;
          default: begin
            op      = OP_CLEAR;
            fin_d   = FIN_OK;
            state_d = S_FIN;
          end
        endcase
      end
      S_LD_RD: begin
        if (sts_i.p_zero) begin
          state_d = S_LD_WR;
        end else begin
          op      = OP_LD_RD;
          state_d = S_LD_CMP;
        end
      end
      S_LD_CMP: begin
        if (sts_i.prd_gt_x) begin
          op      = OP_LD_SHIFT;
          state_d = S_LD_RD;
        end else begin
          state_d = S_LD_WR;
        end
      end
      S_LD_WR: begin
        op      = OP_LD_WR;
        fin_d   = FIN_OK;
        state_d = S_FIN;
      end
      S_AD_NRD: begin
        op      = OP_AD_RD;
        state_d = S_AD_XL;
      end
      S_AD_XL: begin
        if (!sts_i.node_hit) begin
          // An empty node takes the line and the walk ends.
          op      = OP_AD_PUT;
          fin_d   = FIN_OK;
          state_d = S_FIN;
        end else begin
          op      = OP_AD_XL;
          state_d = S_AD_XM;
        end
      end
      S_AD_XM: begin
        op      = OP_AD_XM;
        state_d = S_AD_XR;
      end
      S_AD_XR: begin
        op      = OP_AD_XR;
        state_d = S_AD_MUL;
      end
      S_AD_MUL: begin
        op      = OP_AD_MUL;
        state_d = S_AD_ACC;
      end
      S_AD_ACC: begin
        op      = OP_AD_ACC;
        state_d = sts_i.e_last ? S_AD_DEC : S_AD_MUL;
      end
      S_AD_DEC: begin
        fin_d = FIN_OK;
        if (sts_i.dec_keep) begin
          state_d = S_FIN;
        end else if (sts_i.dec_take) begin
          op      = OP_AD_PUT;
          state_d = S_FIN;
        end else if (sts_i.w_le1) begin
          state_d = S_FIN;
        end else begin
          op      = OP_AD_STEP;
          state_d = S_AD_NRD;
        end
      end
      S_QB_CHK: begin
        if (sts_i.lo_lt_hi) begin
          op      = OP_QB_RD;
          state_d = S_QB_CMP;
        end else begin
          state_d = S_QF_RD;
        end
      end
      S_QB_CMP: begin
        op      = OP_QB_CMP;
        state_d = S_QB_CHK;
      end
      S_QF_RD: begin
        if (sts_i.lo_ge_cnt) begin
          fin_d   = FIN_NF;
          state_d = S_FIN;
        end else begin
          op      = OP_QF_RD;
          state_d = S_QF_CHK;
        end
      end
      S_QF_CHK: begin
        if (sts_i.prd_ne_x) begin
          fin_d   = FIN_NF;
          state_d = S_FIN;
        end else begin
          op      = OP_QW_INIT;
          state_d = S_QW_RD;
        end
      end
      S_QW_RD: begin
        op      = OP_QW_RD;
        state_d = S_QW_MUL;
      end
      S_QW_MUL: begin
        op      = OP_QW_MUL;
        state_d = S_QW_ACC;
      end
      S_QW_ACC: begin
        op = OP_QW_ACC;
        if (sts_i.i_one) begin
          fin_d   = FIN_QRY;
          state_d = S_FIN;
        end else begin
          state_d = S_QW_RD;
        end
      end
      S_FIN: begin
        if (sts_i.out_free) begin
          op      = OP_FIN;
          state_d = sts_i.epoch_zero ? S_SWEEP : S_IDLE;
        end
      end
      S_SWEEP: begin
        op = OP_SWEEP;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      fin_q   <= FIN_OK;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign cmd_o.op   = op;
  assign cmd_o.fin  = fin_q;

endmodule

FILE: sv/mlet_dp.sv
// Datapath: point store, node store with epoch tags, multiplier and result register.
module mlet_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] slope_i,
  input  logic signed [31:0] intercept_i,
  input  logic               out_ready_i,
  input  mlet_pkg::ctl_cmd_t ctl_i,
  output mlet_pkg::dp_sts_t  sts_o,
  output logic               out_valid_o,
  output logic signed [63:0] min_value_o,
  output logic [1:0]         status_o
);
  import mlet_pkg::*;

  function automatic logic [PIDX_W-1:0] leaf(input logic [CNT_W-1:0] idx,
                                             input logic [CNT_W-1:0] cnt);
    logic [CNT_W-1:0] last;
    last = cnt - CNT_W'(1);
    return (idx < cnt) ? idx[PIDX_W-1:0] : last[PIDX_W-1:0];
  endfunction

  // Memories.
  logic [31:0]       pmem [POINTS];
  logic [NODE_W-1:0] nmem [NODES];
  logic              pwe, pre, nwe, nre;
  logic [PIDX_W-1:0] pwa, pra;
  logic [31:0]       pwd, prd_q;
  logic [NIDX_W-1:0] nwa, nra;
  logic [NODE_W-1:0] nwd, nrd_q;

  // Control registers.
  logic [CNT_W-1:0]   count_q, count_d;
  logic [EPOCH_W-1:0] epoch_q, epoch_d;
  logic [NIDX_W-1:0]  sidx_q, sidx_d;
  logic               out_valid_q, out_valid_d;

  // Payload registers.
  logic [1:0]         cmd_q, cmd_d;
  logic signed [31:0] x_q, x_d, a_q, a_d, b_q, b_d;
  logic signed [31:0] xl_q, xl_d, xm_q, xm_d, xr_q, xr_d;
  logic [CNT_W-1:0]   p_q, p_d, w_q, w_d, lo_q, lo_d, hi_q, hi_d;
  logic [PIDX_W-1:0]  l_q, l_d, mid_q, mid_d;
  logic [NIDX_W-1:0]  j_q, j_d, i_q, i_d;
  logic [2:0]         e_q, e_d;
  logic signed [63:0] mul_q, mul_d, best_q, best_d;
  logic signed [63:0] y_q [6];
  logic signed [63:0] y_d [6];
  logic               any_q, any_d, hit_q, hit_d;
  logic signed [63:0] res_q, res_d;
  logic [1:0]         st_q, st_d;

  // Helpers.
  logic [EPOCH_W-1:0] n_tag;
  logic signed [31:0] n_slope, n_int;
  logic signed [31:0] opa, opb, bsel;
  logic [CNT_W:0]     lh_sum;
  logic [CNT_W-1:0]   w_half, idx_mid, idx_right;
  logic               go_right, take_mid;
  logic signed [63:0] qy;

  assign n_tag   = nrd_q[NODE_W-1 -: EPOCH_W];
  assign n_slope = nrd_q[63:32];
  assign n_int   = nrd_q[31:0];

  assign w_half    = w_q >> 1;
  assign idx_mid   = {1'b0, l_q} + w_half;
  assign idx_right = {1'b0, l_q} + w_q - CNT_W'(1);
  assign lh_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign qy        = mul_q + 64'(n_int);

  // Operand order per evaluation: node line at left, middle, right, then new line.
  always_comb begin
    opa  = (e_q < 3'd3) ? n_slope : a_q;
    bsel = (e_q < 3'd3) ? n_int : b_q;
    case (e_q)
      3'd0, 3'd3: opb = xl_q;
      3'd1, 3'd4: opb = xm_q;
      default:    opb = xr_q;
    endcase
  end

  // y_q: 0..2 hold the node line at left, middle, right; 3..5 the carried line.
  assign take_mid = (y_q[1] >= y_q[4]);
  assign go_right = take_mid ? (y_q[2] < y_q[5]) : (y_q[2] >= y_q[5]);

  always_comb begin
    count_d     = count_q;
    epoch_d     = epoch_q;
    sidx_d      = sidx_q;
    out_valid_d = out_valid_q;
    cmd_d = cmd_q;  x_d = x_q;  a_d = a_q;  b_d = b_q;
    xl_d = xl_q;  xm_d = xm_q;  xr_d = xr_q;
    p_d = p_q;  w_d = w_q;  lo_d = lo_q;  hi_d = hi_q;
    l_d = l_q;  mid_d = mid_q;  j_d = j_q;  i_d = i_q;  e_d = e_q;
    mul_d = mul_q;  best_d = best_q;  any_d = any_q;  hit_d = hit_q;
    res_d = res_q;  st_d = st_q;
    y_d = y_q;
    pwe = 1'b0;  pwa = '0;  pwd = '0;  pre = 1'b0;  pra = '0;
    nwe = 1'b0;  nwa = '0;  nwd = '0;  nre = 1'b0;  nra = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (ctl_i.op)
      OP_ACCEPT: begin
        cmd_d = cmd_i;
        x_d   = x_i;
        a_d   = slope_i;
        b_d   = intercept_i;
        p_d   = count_q;
        l_d   = '0;
        j_d   = NIDX_W'(1);
        w_d   = CNT_W'(POINTS);
        lo_d  = '0;
        hi_d  = count_q;
      end
      OP_CLEAR: begin
        count_d = '0;
        epoch_d = epoch_q + EPOCH_W'(1);
      end
      OP_LD_RD: begin
        pre = 1'b1;
        pra = PIDX_W'(p_q - CNT_W'(1));
      end
      OP_LD_SHIFT: begin
        pwe = 1'b1;
        pwa = p_q[PIDX_W-1:0];
        pwd = prd_q;
        p_d = p_q - CNT_W'(1);
      end
      OP_LD_WR: begin
        pwe     = 1'b1;
        pwa     = p_q[PIDX_W-1:0];
        pwd     = x_q;
        count_d = count_q + CNT_W'(1);
        // The leaf layout moved, so every stored line is retired.
        epoch_d = epoch_q + EPOCH_W'(1);
      end
      OP_AD_RD: begin
        nre = 1'b1;
        nra = j_q;
        pre = 1'b1;
        pra = leaf({1'b0, l_q}, count_q);
      end
      OP_AD_PUT: begin
        nwe = 1'b1;
        nwa = j_q;
        nwd = {epoch_q, a_q, b_q};
      end
      OP_AD_XL: begin
        xl_d = prd_q;
        pre  = 1'b1;
        pra  = leaf(idx_mid, count_q);
      end
      OP_AD_XM: begin
        xm_d = prd_q;
        pre  = 1'b1;
        pra  = leaf(idx_right, count_q);
        e_d  = '0;
      end
      OP_AD_XR: xr_d = prd_q;
      OP_AD_MUL: mul_d = opa * opb;
      OP_AD_ACC: begin
        y_d[e_q] = mul_q + 64'(bsel);
        e_d      = e_q + 3'd1;
      end
      OP_AD_STEP: begin
        w_d = w_half;
        if (take_mid) begin
          nwe = 1'b1;
          nwa = j_q;
          nwd = {epoch_q, a_q, b_q};
          a_d = n_slope;
          b_d = n_int;
        end
        j_d = {j_q[NIDX_W-2:0], go_right};
        if (go_right) begin
          l_d = PIDX_W'({1'b0, l_q} + w_half);
        end
      end
      OP_QB_RD: begin
        mid_d = PIDX_W'(lh_sum >> 1);
        pre   = 1'b1;
        pra   = PIDX_W'(lh_sum >> 1);
      end
      OP_QB_CMP: begin
        if ($signed(prd_q) < x_q) begin
          lo_d = {1'b0, mid_q} + CNT_W'(1);
        end else begin
          hi_d = {1'b0, mid_q};
        end
      end
      OP_QF_RD: begin
        pre = 1'b1;
        pra = lo_q[PIDX_W-1:0];
      end
      OP_QW_INIT: begin
        i_d    = {1'b1, lo_q[PIDX_W-1:0]};
        best_d = NO_LINE;
        any_d  = 1'b0;
      end
      OP_QW_RD: begin
        nre = 1'b1;
        nra = i_q;
      end
      OP_QW_MUL: begin
        mul_d = n_slope * x_q;
        hit_d = (n_tag == epoch_q);
      end
      OP_QW_ACC: begin
        if (hit_q && (!any_q || qy < best_q)) begin
          best_d = qy;
        end
        any_d = any_q | hit_q;
        i_d   = i_q >> 1;
      end
      OP_FIN: begin
        out_valid_d = 1'b1;
        case (ctl_i.fin)
          FIN_QRY: begin
            res_d = best_q;
            st_d  = ST_OK;
          end
          FIN_FULL: begin
            res_d = '0;
            st_d  = ST_FULL;
          end
          FIN_NF: begin
            res_d = '0;
            st_d  = ST_NOT_FOUND;
          end
          default: begin
            res_d = '0;
            st_d  = ST_OK;
          end
        endcase
      end
      OP_SWEEP: begin
        // Tag zero never matches a live epoch, which runs from one upward.
        nwe    = 1'b1;
        nwa    = sidx_q;
        nwd    = '0;
        sidx_d = sidx_q + NIDX_W'(1);
        if (sidx_q == NIDX_W'(NODES - 1)) begin
          epoch_d = EPOCH_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pwe) begin
      pmem[pwa] <= pwd;
    end
    if (pre) begin
      prd_q <= pmem[pra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (nwe) begin
      nmem[nwa] <= nwd;
    end
    if (nre) begin
      nrd_q <= nmem[nra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      epoch_q     <= '0;
      sidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      epoch_q     <= epoch_d;
      sidx_q      <= sidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;  x_q <= x_d;  a_q <= a_d;  b_q <= b_d;
    xl_q <= xl_d;  xm_q <= xm_d;  xr_q <= xr_d;
    p_q <= p_d;  w_q <= w_d;  lo_q <= lo_d;  hi_q <= hi_d;
    l_q <= l_d;  mid_q <= mid_d;  j_q <= j_d;  i_q <= i_d;  e_q <= e_d;
    mul_q <= mul_d;  best_q <= best_d;  any_q <= any_d;  hit_q <= hit_d;
    res_q <= res_d;  st_q <= st_d;
    y_q <= y_d;
  end

  assign sts_o.cmd        = cmd_q;
  assign sts_o.cnt_full   = (count_q == CNT_W'(POINTS));
  assign sts_o.cnt_zero   = (count_q == '0);
  assign sts_o.epoch_zero = (epoch_q == '0);
  assign sts_o.sweep_last = (sidx_q == NIDX_W'(NODES - 1));
  assign sts_o.p_zero     = (p_q == '0);
  assign sts_o.prd_gt_x   = ($signed(prd_q) > x_q);
  assign sts_o.prd_ne_x   = ($signed(prd_q) != x_q);
  assign sts_o.lo_lt_hi   = (lo_q < hi_q);
  assign sts_o.lo_ge_cnt  = (lo_q >= count_q);
  assign sts_o.node_hit   = (n_tag == epoch_q);
  assign sts_o.dec_keep   = (y_q[0] <= y_q[3]) && (y_q[2] <= y_q[5]);
  assign sts_o.dec_take   = (y_q[0] >= y_q[3]) && (y_q[2] >= y_q[5]);
  assign sts_o.w_le1      = (w_q <= CNT_W'(1));
  assign sts_o.e_last     = (e_q == 3'd5);
  assign sts_o.i_one      = (i_q == NIDX_W'(1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign min_value_o = res_q;
  assign status_o    = st_q;

endmodule

FILE: sv/min_line_envelope_tree_unit.sv
// Top level of the lower-envelope line tree: controller plus datapath.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, cmd, x, slope, int | into block
//  out     | out_valid_o/out_ready_i, min_value, status| out of block
//
// One item is worked on at a time. A load moves every stored point greater than the
// new one up by one place, then writes the new point. Add line works down the tree,
// up to 11 levels; each level takes three point reads and six products through the
// one 32x32 multiplier. A query runs a binary search over the points, then visits
// each node on the leaf-to-root path (11 nodes). After reset, and after every 255th
// load or clear, a tag clearing pass runs over the node memory with in_ready_o low.
// A waiting result does not block acceptance of the next item.
module min_line_envelope_tree_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] x_i,
  input  logic signed [31:0] slope_i,
  input  logic signed [31:0] intercept_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] min_value_o,
  output logic [1:0]         status_o
);
  import mlet_pkg::*;

  ctl_cmd_t ctl;
  dp_sts_t  sts;

  mlet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (ctl)
  );

  mlet_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .x_i         (x_i),
    .slope_i     (slope_i),
    .intercept_i (intercept_i),
    .out_ready_i (out_ready_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .min_value_o (min_value_o),
    .status_o    (status_o)
  );

endmodule

FILE: sv/mlet_checker.sv
// Port-level checker for the line envelope tree and its bind to the top level.
module mlet_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [1:0]         cmd_i,
  input logic signed [31:0] x_i,
  input logic signed [31:0] slope_i,
  input logic signed [31:0] intercept_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [63:0] min_value_o,
  input logic [1:0]         status_o
);
  import mlet_pkg::*;

  // A stalled result transfer holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(min_value_o) && $stable(status_o))
    else $error("result changed while stalled");

  // Only one item is in work, so input ready drops after each transfer.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in work");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_FULL)
    else $error("undefined status code");

  // Failure results carry a zero value.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> min_value_o == 64'sd0)
    else $error("nonzero value on a failed result");

endmodule

bind min_line_envelope_tree_unit mlet_checker u_chk (.*);

FILE: tb/tb_min_line_envelope_tree_unit.sv
// Self-checking testbench for the line envelope tree: random commands against a behavioral tree.
`timescale 1ns / 1ps

class envelope_scoreboard;
  logic signed [31:0] pts[$];
  logic signed [31:0] nslope[2048];
  logic signed [31:0] nicpt[2048];
  bit                 nvalid[2048];
  logic signed [63:0] exp_value[$];
  logic [1:0]         exp_status[$];
  int                 errors;

  function logic signed [31:0] leaf_x(int i);
    if (i < pts.size()) return pts[i];
    return pts[pts.size() - 1];
  endfunction

  function logic signed [63:0] eval(logic signed [31:0] a, logic signed [31:0] b,
                                    logic signed [31:0] x);
    logic signed [63:0] p;
    p = 64'(a) * 64'(x);
    return p + 64'(b);
  endfunction

  function void drop_lines();
    foreach (nvalid[k]) nvalid[k] = 0;
  endfunction

  function void insert_line(logic signed [31:0] a, logic signed [31:0] b);
    int l, j, w;
    logic signed [31:0] a0, b0, xl, xm, xr;
    logic signed [63:0] yl0, ym0, yr0, yl, ym, yr;
    l = 0; j = 1; w = mlet_pkg::POINTS;
    while (j < 2 * mlet_pkg::POINTS) begin
      if (!nvalid[j]) begin
        nslope[j] = a; nicpt[j] = b; nvalid[j] = 1;
        return;
      end
      xl = leaf_x(l); xm = leaf_x(l + w / 2); xr = leaf_x(l + w - 1);
      a0 = nslope[j]; b0 = nicpt[j];
      yl0 = eval(a0, b0, xl); ym0 = eval(a0, b0, xm); yr0 = eval(a0, b0, xr);
      yl = eval(a, b, xl); ym = eval(a, b, xm); yr = eval(a, b, xr);
      if (yl0 <= yl && yr0 <= yr) return;
      if (yl0 >= yl && yr0 >= yr) begin
        nslope[j] = a; nicpt[j] = b;
        return;
      end
      if (w <= 1) return;
      w = w >> 1;
      if (ym0 >= ym) begin
        nslope[j] = a; nicpt[j] = b;
        a = a0; b = b0;
        j = j << 1;
        if (yr0 < yr) begin j = j | 1; l += w; end
      end else begin
        j = j << 1;
        if (yr0 >= yr) begin j = j | 1; l += w; end
      end
    end
  endfunction

  function void note_input(logic [1:0] cmd, logic signed [31:0] x,
                           logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] v, y;
    logic [1:0] st;
    int p, i;
    bit any;
    v = 0; st = mlet_pkg::ST_OK;
    case (cmd)
      mlet_pkg::CMD_LOAD: begin
        if (pts.size() >= mlet_pkg::POINTS) st = mlet_pkg::ST_FULL;
        else begin
          p = pts.size();
          while (p > 0 && pts[p - 1] > x) p--;
          pts.insert(p, x);
          drop_lines();
        end
      end
      mlet_pkg::CMD_ADD: if (pts.size() > 0) insert_line(a, b);
      mlet_pkg::CMD_QUERY: begin
        p = 0;
        while (p < pts.size() && pts[p] < x) p++;
        if (p >= pts.size() || pts[p] != x) st = mlet_pkg::ST_NOT_FOUND;
        else begin
          v = mlet_pkg::NO_LINE; any = 0;
          for (i = p + mlet_pkg::POINTS; i > 0; i = i >> 1)
            if (nvalid[i]) begin
              y = eval(nslope[i], nicpt[i], x);
              if (!any || y < v) v = y;
              any = 1;
            end
        end
      end
      default: begin
        pts.delete();
        drop_lines();
      end
    endcase
    exp_value.push_back(v);
    exp_status.push_back(st);
  endfunction

  function void report(string msg);
    errors++;
    if (errors <= 50) $display("mismatch: %s", msg);
  endfunction

  function void check_result(logic signed [63:0] v, logic [1:0] st);
    logic signed [63:0] ev;
    logic [1:0] es;
    if (exp_value.size() == 0) begin
      report($sformatf("unexpected result value=%0d status=%0d", v, st));
      return;
    end
    ev = exp_value.pop_front();
    es = exp_status.pop_front();
    if (v !== ev) report($sformatf("min_value got %0d want %0d", v, ev));
    if (st !== es) report($sformatf("status got %0d want %0d", st, es));
  endfunction
endclass

module tb_min_line_envelope_tree_unit;
  import mlet_pkg::*;

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               in_valid_i = 0;
  logic               in_ready_o;
  logic [1:0]         cmd_i = CMD_CLEAR;
  logic signed [31:0] x_i = 0;
  logic signed [31:0] slope_i = 0;
  logic signed [31:0] intercept_i = 0;
  logic               out_valid_o;
  logic               out_ready_i = 0;
  logic signed [63:0] min_value_o;
  logic [1:0]         status_o;

  envelope_scoreboard sb;
  bit                 out_stalls = 1;
  logic signed [31:0] loaded[$];

  min_line_envelope_tree_unit u_dut (.*);

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  // Send one command. Valid is dropped only for a nonzero gap, so a back-to-back
  // item keeps it high and just replaces the payload at the transfer edge.
  task automatic send(logic [1:0] cmd, logic signed [31:0] x,
                      logic signed [31:0] a, logic signed [31:0] b, bit nogap = 0);
    int gap;
    gap = nogap ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1; cmd_i <= cmd; x_i <= x; slope_i <= a; intercept_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cmd, x, a, b);
    if (cmd == CMD_LOAD) loaded.push_back(x);
    if (cmd == CMD_CLEAR) loaded.delete();
  endtask

  task automatic drain();
    in_valid_i <= 0;
    @(posedge clk_i);
    while (sb.exp_value.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_x();
    if (loaded.size() > 0 && $urandom_range(0, 9) < 8)
      return loaded[$urandom_range(0, loaded.size() - 1)];
    return $urandom;
  endfunction

  function automatic logic signed [31:0] small_val();
    return $urandom_range(0, 3) == 0 ? $urandom : $signed($urandom_range(0, 2000)) - 1000;
  endfunction

  // Receiver with a random per-result stall while out_stalls is set.
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = out_stalls ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_ready_i <= 0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(min_value_o, status_o);
    end
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int n, k, m;
    logic signed [31:0] xs;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // Directed: empty store, extremes, ties, duplicates.
    send(CMD_QUERY, 0, 0, 0);
    send(CMD_ADD, 0, 5, 5);
    send(CMD_LOAD, 32'sh7FFF_FFFF, 0, 0);
    send(CMD_LOAD, 32'sh8000_0000, 0, 0);
    send(CMD_LOAD, 0, 0, 0);
    send(CMD_LOAD, 0, 0, 0);
    send(CMD_QUERY, 0, 0, 0);
    send(CMD_ADD, 0, 32'sh8000_0000, 32'sh8000_0000);
    send(CMD_ADD, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send(CMD_ADD, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send(CMD_ADD, 0, 0, -1);
    send(CMD_ADD, 0, -1, 0);
    send(CMD_QUERY, 32'sh8000_0000, 0, 0);
    send(CMD_QUERY, 32'sh7FFF_FFFF, 0, 0);
    send(CMD_QUERY, 0, 0, 0);
    send(CMD_QUERY, 5, 0, 0);
    send(CMD_LOAD, 3, 0, 0);
    send(CMD_QUERY, 3, 0, 0);
    send(CMD_CLEAR, 0, 0, 0);
    send(CMD_QUERY, 3, 0, 0);
    drain();

    // Fill the store to capacity with no idling, then overfill, add lines and query.
    out_stalls = 0;
    for (k = 0; k < POINTS; k++) send(CMD_LOAD, $urandom, 0, 0, 1);
    send(CMD_LOAD, 7, 0, 0);
    for (k = 0; k < 40; k++) send(CMD_ADD, 0, $urandom, $urandom, 1);
    for (k = 0; k < 40; k++) send(CMD_QUERY, pick_x(), 0, 0, 1);
    out_stalls = 1;
    send(CMD_CLEAR, 0, 0, 0);
    drain();

    // Random sessions: small point sets, then mostly lines and queries with some loads, and clears.
    n = 0;
    while (n < 700) begin
      m = $urandom_range(1, 20);
      for (k = 0; k < m; k++) begin
        xs = $urandom_range(0, 1) ? small_val() : pick_x();
        send(CMD_LOAD, xs, $urandom, $urandom);
      end
      for (k = 0; k < 30; k++) begin
        case ($urandom_range(0, 19))
          0: send(CMD_LOAD, small_val(), 0, 0);
          1: send(CMD_QUERY, $urandom, 0, 0);
          2, 3, 4, 5, 6, 7, 8, 9: send(CMD_ADD, $urandom, small_val(), $urandom);
          default: send(CMD_QUERY, pick_x(), $urandom, $urandom);
        endcase
      end
      n += m + 30;
      if ($urandom_range(0, 2) == 0) send(CMD_CLEAR, $urandom, $urandom, $urandom);
      if ($urandom_range(0, 4) == 0) drain();
    end

    drain();
    repeat (3000) @(posedge clk_i);
    if (sb.errors == 0 && sb.exp_value.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
